>>> sv/vtgd_pkg.sv
package vtgd_pkg;

   localparam logic [11:0] WINDOW_Y_MAX = 12'd3121;
   localparam int unsigned FIFO_DEPTH = 4;

   typedef enum logic [1:0] {
      ACT_UPDATE = 2'd0,
      ACT_MOVE   = 2'd1,
      ACT_DRAW   = 2'd2
   } action_type;

   // byte class from code bits 6:5
   typedef enum logic [1:0] {
      KIND_CONTROL = 2'b00,
      KIND_HIGH    = 2'b01,
      KIND_LOW_X   = 2'b10,
      KIND_LOW_Y   = 2'b11
   } kind_type;

   typedef struct packed {
      logic        last;
      logic [11:0] y;
      logic [11:0] x;
      action_type  action;
   } result_type;

   // results caused by one decoded byte
   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } decode_out_type;

endpackage

>>> sv/vtgd_decode.sv
module vtgd_decode (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic [6:0]              code,
   input  logic                    force_move,
   input  logic [13:0]             min_seg,
   output vtgd_pkg::decode_out_type dec
);
   import vtgd_pkg::*;

   logic [4:0]  high_x_ff, high_x_in, high_y_ff, high_y_in, low_y_ff, low_y_in;
   logic [1:0]  extra_x_ff, extra_x_in, extra_y_ff, extra_y_in;
   logic        expect_high_x_ff, expect_high_x_in, draw_flag_ff, draw_flag_in;
   logic [11:0] current_x_ff, current_x_in, current_y_ff, current_y_in;
   logic [11:0] pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;

   logic        df;
   logic [11:0] pt_x, pt_y, dx, dy;
   logic [12:0] len;
   logic        cur_in, new_in, moved, allow, draw;
   result_type  r_move, r_draw, r_upd;

   assign pt_x = {high_x_ff, code[4:0], extra_x_ff};
   assign pt_y = {high_y_ff, low_y_ff, extra_y_ff};
   assign df   = draw_flag_ff & ~force_move;

   assign cur_in = current_y_ff <= WINDOW_Y_MAX;
   assign new_in = pt_y <= WINDOW_Y_MAX;
   assign moved  = df && ((pen_x_ff != current_x_ff) || (pen_y_ff != current_y_ff)) && cur_in;
   assign dx     = (current_x_ff > pt_x) ? current_x_ff - pt_x : pt_x - current_x_ff;
   assign dy     = (current_y_ff > pt_y) ? current_y_ff - pt_y : pt_y - current_y_ff;
   assign len    = {1'b0, dx} + {1'b0, dy};
   // 2*len tops out at 16380, fits 14 bits
   assign allow  = moved || ({len, 1'b0} >= min_seg);
   assign draw   = df && allow && cur_in && new_in;

   always_comb begin
      r_move = '{last: ~draw, y: current_y_ff, x: current_x_ff, action: ACT_MOVE};
      r_draw = '{last: 1'b1, y: pt_y, x: pt_x, action: ACT_DRAW};
      r_upd  = '{last: 1'b1, y: pt_y, x: pt_x, action: ACT_UPDATE};

      high_x_in        = high_x_ff;
      high_y_in        = high_y_ff;
      low_y_in         = low_y_ff;
      extra_x_in       = extra_x_ff;
      extra_y_in       = extra_y_ff;
      expect_high_x_in = expect_high_x_ff;
      draw_flag_in     = df;
      current_x_in     = current_x_ff;
      current_y_in     = current_y_ff;
      pen_x_in         = pen_x_ff;
      pen_y_in         = pen_y_ff;
      dec              = '{count: 2'd0, res0: r_upd, res1: r_draw};

      case (kind_type'(code[6:5]))
         KIND_HIGH: begin
            if (expect_high_x_ff) begin
               high_x_in = code[4:0];
            end else begin
               high_y_in = code[4:0];
            end
         end
         KIND_LOW_Y: begin
            extra_x_in       = low_y_ff[1:0];
            extra_y_in       = low_y_ff[3:2];
            low_y_in         = code[4:0];
            expect_high_x_in = 1'b1;
         end
         KIND_LOW_X: begin
            current_x_in     = pt_x;
            current_y_in     = pt_y;
            draw_flag_in     = 1'b1;
            expect_high_x_in = 1'b0;
            if (draw) begin
               pen_x_in = pt_x;
               pen_y_in = pt_y;
            end else if (moved) begin
               pen_x_in = current_x_ff;
               pen_y_in = current_y_ff;
            end
            if (moved) begin
               dec.res0  = r_move;
               dec.count = draw ? 2'd2 : 2'd1;
            end else if (draw) begin
               dec.res0  = r_draw;
               dec.count = 2'd1;
            end else begin
               dec.count = 2'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_x_ff        <= '0;
         high_y_ff        <= '0;
         low_y_ff         <= '0;
         extra_x_ff       <= '0;
         extra_y_ff       <= '0;
         expect_high_x_ff <= 1'b0;
         draw_flag_ff     <= 1'b0;
         current_x_ff     <= '0;
         current_y_ff     <= '0;
         pen_x_ff         <= '0;
         pen_y_ff         <= '0;
      end else if (fire) begin
         high_x_ff        <= high_x_in;
         high_y_ff        <= high_y_in;
         low_y_ff         <= low_y_in;
         extra_x_ff       <= extra_x_in;
         extra_y_ff       <= extra_y_in;
         expect_high_x_ff <= expect_high_x_in;
         draw_flag_ff     <= draw_flag_in;
         current_x_ff     <= current_x_in;
         current_y_ff     <= current_y_in;
         pen_x_ff         <= pen_x_in;
         pen_y_ff         <= pen_y_in;
      end
   end

endmodule

>>> sv/vtgd_result_fifo.sv
module vtgd_result_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  vtgd_pkg::decode_out_type dec,
   input  logic                     pop,
   output logic                     room2,
   output logic                     not_empty,
   output vtgd_pkg::result_type     head
);
   import vtgd_pkg::*;

   localparam int PW = $clog2(FIFO_DEPTH);

   result_type    mem_ff [FIFO_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in, push_n;
   logic [PW-1:0] wr_next;

   assign push_n    = push ? {{(PW-1){1'b0}}, dec.count} : '0;
   assign wr_next   = wr_ptr_ff + PW'(1);
   assign not_empty = count_ff != '0;
   assign head      = mem_ff[rd_ptr_ff];
   // at least two free slots after this cycle's pop
   assign room2     = (count_ff - {{PW{1'b0}}, pop}) <= (PW+1)'(FIFO_DEPTH - 2);
   assign wr_ptr_in = wr_ptr_ff + push_n[PW-1:0];
   assign rd_ptr_in = rd_ptr_ff + {{(PW-1){1'b0}}, pop};
   assign count_in  = count_ff + push_n - {{PW{1'b0}}, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && dec.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= dec.res0;
      end
      if (push && dec.count == 2'd2) begin
         mem_ff[wr_next] <= dec.res1;
      end
   end

endmodule

>>> sv/vector_terminal_graphics_decoder.sv
// Vector terminal graphics-mode decoder.
// req_ channel: one graphics byte per word (tdata[6:0]); tuser is the
// force-move flag, which clears the draw flag before the byte is decoded.
// rsp_ channel: plotter results, tdata = action, x, y; tlast marks the
// final result caused by one byte. High-part and low-y bytes and control
// codes give no result; a low-x byte gives one or two (move, then draw).
// csr_: write enable and data for the minimum segment length (in halves),
// taken at any edge with csr_wr_en high; write it only while idle.
// The input register captures an accepted byte; the byte is decoded
// from it once the queue has room, and its results enter the queue.
// Throughput: one byte per cycle while the queue has room; the single
// output port sets the limit, so a byte with two results needs two
// output transfers. Decoding needs two free slots in the 4-entry queue.
// Reset (synchronous): all coordinate state, the pen and the register go
// to zero, the queue and the input register empty. req_tready is held
// low while reset is high.
// A stalled receiver fills the queue; the input register then holds its
// byte and req_tready drops until space returns. Nothing is dropped.
module vector_terminal_graphics_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [6:0] code_byte, [7] zero
   input  logic        req_tuser,   // [0] force_move
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [1:0] action, [13:2] coord_x, [25:14] coord_y, rest zero
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [13:0] csr_wr_data
);
   import vtgd_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic [6:0]     code_ff;
   logic           force_ff;
   logic [13:0]    min_seg_ff;
   logic           fire, room2, pop, not_empty;
   decode_out_type dec;
   result_type     head;

   // decode when a byte waits and the queue can take two results
   assign fire        = in_valid_ff && room2;
   assign req_tready  = !reset && (!in_valid_ff || fire);
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         min_seg_ff  <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            min_seg_ff <= csr_wr_data;
         end
      end
   end

   // payload of the input register
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         code_ff  <= req_tdata[6:0];
         force_ff <= req_tuser;
      end
   end

   vtgd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .code       (code_ff),
      .force_move (force_ff),
      .min_seg    (min_seg_ff),
      .dec        (dec)
   );

   assign pop = rsp_tvalid && rsp_tready;

   vtgd_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fire),
      .dec       (dec),
      .pop       (pop),
      .room2     (room2),
      .not_empty (not_empty),
      .head      (head)
   );

   assign rsp_tvalid = not_empty;
   assign rsp_tdata  = {6'b0, head.y, head.x, head.action};
   assign rsp_tlast  = head.last;

   // a byte never causes more than two results
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      fire |-> dec.count != 2'd3)
      else $error("decoder produced more than two results");

   // a pair is always move then draw, the draw closing the run
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (fire && dec.count == 2'd2) |->
         (dec.res0.action == ACT_MOVE && !dec.res0.last &&
          dec.res1.action == ACT_DRAW && dec.res1.last))
      else $error("bad two-result ordering");

   // a single result closes its run
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (fire && dec.count == 2'd1) |-> dec.res0.last)
      else $error("single result without last");

   // an accepted byte is held until decoded
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> (in_valid_ff && $stable(code_ff)))
      else $error("waiting byte lost");

endmodule

>>> verif/tb_vector_terminal_graphics_decoder.sv
// Testbench for the vector terminal graphics-mode decoder.
// A scoreboard model tracks the coordinate registers, the pen and the
// minimum segment length, and queues the plot results each accepted word
// should cause. A receive process checks every rsp_ word against the
// oldest queued result. The sender works in random bursts. The receiver
// runs its own ready pattern: steady, random, or long stalls.
module tb_vector_terminal_graphics_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import vtgd_pkg::*;

   localparam int  RESET_CYCLES  = 12;
   localparam int  SETTLE_CYCLES = 8;        // covers input reg + decode + queue
   localparam int  IDLE_GUARD    = 20000;    // cycles allowed to drain the queue
   localparam int  MAX_REPORTS   = 50;       // cap on mismatch lines
   localparam int  PHASE_WORDS   = 275;      // decoded words per random phase
   localparam time WATCHDOG_NS   = 5_000_000;

   typedef enum int {
      RX_STEADY,
      RX_RANDOM,
      RX_STALLS
   } rx_mode_type;

   // DUT ports; the inputs are known from time zero
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;   // [6:0] code_byte, [7] zero
   logic        req_tuser   = 1'b0; // [0] force_move
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;          // [1:0] action, [13:2] x, [25:14] y
   logic        rsp_tlast;
   logic        csr_wr_en   = 1'b0;
   logic [13:0] csr_wr_data = '0;

   // scoreboard copy of the decoder state
   logic [13:0] min_seg_halves = '0;
   logic [4:0]  hx_part   = '0;
   logic [4:0]  hy_part   = '0;
   logic [4:0]  ly_part   = '0;
   logic [1:0]  ext_x     = '0;
   logic [1:0]  ext_y     = '0;
   logic        sel_high_x = 1'b0;
   logic        drawing   = 1'b0;
   logic [11:0] cur_x     = '0;
   logic [11:0] cur_y     = '0;
   logic [11:0] pen_pos_x = '0;
   logic [11:0] pen_pos_y = '0;

   result_type  pending_plots [$];

   // run bookkeeping
   int fail_count     = 0;
   int words_sent     = 0;
   int decoded_words  = 0;   // words that are not control codes
   int plots_checked  = 0;
   int settings_used  = 0;
   int burst_left     = 0;

   // receiver pattern state
   rx_mode_type rx_mode    = RX_STEADY;
   int          mode_left  = 0;
   int          stall_left = 0;
   logic        ready_next;

   vector_terminal_graphics_decoder uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   initial begin
      #WATCHDOG_NS;
      $display("%0t: timeout, %0d results still expected", $time, pending_plots.size());
      $display("Verification failed");
      $finish;
   end

   function automatic result_type make_plot(input action_type act, input logic [11:0] x,
                                            input logic [11:0] y);
      result_type r;
      r.action = act;
      r.x      = x;
      r.y      = y;
      r.last   = 1'b0;
      return r;
   endfunction

   // Decode one graphics word against the tracked state and queue its results.
   task automatic decode_graphics_byte(input logic [6:0] code, input logic force_mv);
      result_type  res [2];
      int          n;
      int          seg_len;
      logic [11:0] px;
      logic [11:0] py;
      logic        cur_in;
      logic        allow;
      n = 0;
      if (force_mv)
         drawing = 1'b0;
      case (kind_type'(code[6:5]))
         KIND_HIGH: begin
            if (sel_high_x)
               hx_part = code[4:0];
            else
               hy_part = code[4:0];
         end
         KIND_LOW_Y: begin
            // extra bits come from the previous low-y value
            ext_x      = ly_part[1:0];
            ext_y      = ly_part[3:2];
            ly_part    = code[4:0];
            sel_high_x = 1'b1;
         end
         KIND_LOW_X: begin
            px = {hx_part, code[4:0], ext_x};
            py = {hy_part, ly_part, ext_y};
            if (!drawing) begin
               res[n++] = make_plot(ACT_UPDATE, px, py);
            end else begin
               cur_in = (cur_y <= WINDOW_Y_MAX);
               if ((pen_pos_x != cur_x || pen_pos_y != cur_y) && cur_in) begin
                  // pen elsewhere: move to the current point first
                  res[n++]  = make_plot(ACT_MOVE, cur_x, cur_y);
                  pen_pos_x = cur_x;
                  pen_pos_y = cur_y;
                  allow     = 1'b1;
               end else begin
                  seg_len = ((cur_x > px) ? int'(cur_x - px) : int'(px - cur_x))
                          + ((cur_y > py) ? int'(cur_y - py) : int'(py - cur_y));
                  allow = (2 * seg_len >= int'(min_seg_halves));
               end
               if (allow && cur_in && (py <= WINDOW_Y_MAX)) begin
                  res[n++]  = make_plot(ACT_DRAW, px, py);
                  pen_pos_x = px;
                  pen_pos_y = py;
               end
               if (n == 0)
                  res[n++] = make_plot(ACT_UPDATE, px, py);
            end
            cur_x      = px;
            cur_y      = py;
            drawing    = 1'b1;
            sel_high_x = 1'b0;
            res[n-1].last = 1'b1;
            for (int i = 0; i < n; i++)
               pending_plots.push_back(res[i]);
         end
         default: ;  // control codes only take the force-move flag
      endcase
   endtask

   // Send one word; bursts of random length with random gaps in between.
   task automatic send_byte(input logic [6:0] code, input logic force_mv);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, code};
      req_tuser  <= force_mv;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      decode_graphics_byte(code, force_mv);
      words_sent++;
      if (code[6:5] != KIND_CONTROL)
         decoded_words++;
   endtask

   // Hold off the sender until every queued result has been seen or the
   // IDLE_GUARD bound runs out, then let the pipeline clear while idle.
   task automatic wait_idle();
      int guard;
      req_tvalid <= 1'b0;
      burst_left = 0;
      guard = 0;
      while (pending_plots.size() != 0 && guard < IDLE_GUARD) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_min_segment(input logic [13:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en      <= 1'b0;
      min_seg_halves = value;
      settings_used++;
   endtask

   task automatic check_plot();
      result_type want;
      if (pending_plots.size() == 0) begin
         if (fail_count < MAX_REPORTS)
            $display("%0t: unexpected result, expected none, actual tdata %h last %b",
                     $time, rsp_tdata, rsp_tlast);
         fail_count++;
         return;
      end
      want = pending_plots.pop_front();
      plots_checked++;
      if (rsp_tdata[1:0] != want.action) begin
         if (fail_count < MAX_REPORTS)
            $display("%0t: action mismatch, expected %0d actual %0d",
                     $time, want.action, rsp_tdata[1:0]);
         fail_count++;
      end
      if (rsp_tdata[13:2] != want.x) begin
         if (fail_count < MAX_REPORTS)
            $display("%0t: coord_x mismatch, expected %0d actual %0d",
                     $time, want.x, rsp_tdata[13:2]);
         fail_count++;
      end
      if (rsp_tdata[25:14] != want.y) begin
         if (fail_count < MAX_REPORTS)
            $display("%0t: coord_y mismatch, expected %0d actual %0d",
                     $time, want.y, rsp_tdata[25:14]);
         fail_count++;
      end
      if (rsp_tlast != want.last) begin
         if (fail_count < MAX_REPORTS)
            $display("%0t: last_of_run mismatch, expected %b actual %b",
                     $time, want.last, rsp_tlast);
         fail_count++;
      end
   endtask

   // Receive side: check on each handshake, then pick next ready value.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_plot();
      if (stall_left > 0) begin
         stall_left--;
         ready_next = 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(32, 256);
         end
         mode_left--;
         case (rx_mode)
            RX_STEADY: ready_next = 1'b1;
            RX_RANDOM: ready_next = ($urandom_range(0, 3) != 0);
            default: begin
               // mostly ready, now and then a long stall
               ready_next = 1'b1;
               if ($urandom_range(0, 15) == 0) begin
                  stall_left = $urandom_range(1, 20);
                  ready_next = 1'b0;
               end
            end
         endcase
      end
      rsp_tready <= ready_next;
   end

   // Reset state, every byte class at its extremes, force-move, control codes.
   task automatic test_corner_bytes();
      send_byte(7'h00, 1'b0);   // control, ignored
      send_byte(7'h3F, 1'b0);   // high y 31
      send_byte(7'h7F, 1'b0);   // low y 31
      send_byte(7'h3F, 1'b0);   // high x 31 (after low y)
      send_byte(7'h5F, 1'b0);   // first point: silent update at top corner
      send_byte(7'h60, 1'b0);   // low y 0, extras 3/3 from old low y
      send_byte(7'h20, 1'b0);   // high x 0
      send_byte(7'h40, 1'b0);   // current point above window: update only
      send_byte(7'h20, 1'b0);   // high y 0
      send_byte(7'h40, 1'b0);   // previous point still outside: update
      send_byte(7'h41, 1'b0);   // pen away: move then draw
      send_byte(7'h41, 1'b0);   // zero length at pen, min 0: draw
      send_byte(7'h42, 1'b1);   // force move: update only
      send_byte(7'h1F, 1'b1);   // control with force move
      send_byte(7'h43, 1'b0);   // update after cleared draw flag
   endtask

   // Largest minimum length, then the window edge at y = 3121.
   task automatic test_min_segment_limits();
      write_min_segment(14'h3FFF);
      send_byte(7'h5F, 1'b0);   // pen away: move and draw regardless of length
      send_byte(7'h5E, 1'b0);   // pen at current, too short: update
      send_byte(7'h38, 1'b0);   // high y 24
      send_byte(7'h64, 1'b0);   // low y 4
      send_byte(7'h6C, 1'b0);   // low y 12, extra y 1 -> y = 3121
      send_byte(7'h20, 1'b0);   // high x 0
      send_byte(7'h40, 1'b0);   // point on the window edge
      send_byte(7'h6C, 1'b0);   // extra y 3 -> y = 3123, just outside
      send_byte(7'h41, 1'b0);   // point outside the window
   endtask

   // Mostly well-formed point records with random content, some noise
   // and some records cut short.
   task automatic test_random_plotting(input logic [13:0] min_halves, input int n_words);
      int   target;
      int   pick;
      int   reps;
      logic fm;
      write_min_segment(min_halves);
      target = decoded_words + n_words;
      while (decoded_words < target) begin
         pick = $urandom_range(0, 9);
         fm   = ($urandom_range(0, 15) == 0);
         if (pick < 3) begin
            // short step: only low x changes
            send_byte({KIND_LOW_X, 5'($urandom)}, fm);
         end else if (pick < 8) begin
            if ($urandom_range(0, 1)) begin
               send_byte({KIND_HIGH, 5'($urandom)}, fm);
               fm = 1'b0;
            end
            reps = $urandom_range(0, 2);
            repeat (reps) begin
               send_byte({KIND_LOW_Y, 5'($urandom)}, fm);
               fm = 1'b0;
            end
            if ($urandom_range(0, 1)) begin
               send_byte({KIND_HIGH, 5'($urandom)}, fm);
               fm = 1'b0;
            end
            send_byte({KIND_LOW_X, 5'($urandom)}, fm);
         end else if (pick == 8) begin
            send_byte(7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
         end else begin
            // broken record: no closing low-x byte
            send_byte({($urandom_range(0, 1) ? KIND_HIGH : KIND_LOW_Y), 5'($urandom)}, fm);
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_bytes();
      test_min_segment_limits();
      test_random_plotting(14'd0, PHASE_WORDS);
      test_random_plotting(14'h3FFF, PHASE_WORDS);
      test_random_plotting(14'($urandom_range(1, 64)), PHASE_WORDS);
      test_random_plotting(14'($urandom_range(65, 400)), PHASE_WORDS);
      test_random_plotting(14'($urandom_range(0, 16383)), PHASE_WORDS);
      test_random_plotting(14'd1, PHASE_WORDS);

      wait_idle();
      if (pending_plots.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, pending_plots.size());
         fail_count += pending_plots.size();
      end
      $display("Sent %0d words (%0d non-control), checked %0d plot results",
               words_sent, decoded_words, plots_checked);
      $display("over %0d minimum-segment settings, with sender gaps and receiver stalls",
               settings_used);
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

>>> files.f
sv/vtgd_pkg.sv
sv/vtgd_decode.sv
sv/vtgd_result_fifo.sv
sv/vector_terminal_graphics_decoder.sv
verif/tb_vector_terminal_graphics_decoder.sv
